### sv/evws_pkg.sv
// ----------------------------------------------------------------------------
// evws_pkg: shared constants and tables for the eight-voice wavetable synth
// Operation codes, waveform codes, noise seed, phase multiplier and the
// quarter-wave sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package evws_pkg;

  // input operation codes
  localparam logic [1:0] OP_REG_WR = 2'd0;
  localparam logic [1:0] OP_PCM_WR = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register index (paddr[2])
  localparam logic CFG_IDX_MUTE = 1'b0;

  // waveform codes in flags0[2:0]
  localparam logic [2:0] WAVE_PULSE     = 3'd0;
  localparam logic [2:0] WAVE_SAW       = 3'd1;
  localparam logic [2:0] WAVE_SINE      = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE  = 3'd3;
  localparam logic [2:0] WAVE_NOISE     = 3'd4;
  localparam logic [2:0] WAVE_PNOISE    = 3'd5;
  localparam logic [2:0] WAVE_PULSE_SIN = 3'd6;
  localparam logic [2:0] WAVE_PULSE_TRI = 3'd7;

  localparam logic [31:0] NOISE_SEED = 32'h0000_AAAA;
  localparam int PHASE_MULT = 1;
  localparam int PCM_RAM_BYTES_DEF = 8192;

  // quarter sine, trunc(sin(i*pi/128)*127) for i = 0..64
  function automatic logic [6:0] sine_quarter(input logic [6:0] q);
    logic [6:0] m;
    case (q)
      7'd0: m = 7'd0;     7'd1: m = 7'd3;     7'd2: m = 7'd6;     7'd3: m = 7'd9;
      7'd4: m = 7'd12;    7'd5: m = 7'd15;    7'd6: m = 7'd18;    7'd7: m = 7'd21;
      7'd8: m = 7'd24;    7'd9: m = 7'd27;    7'd10: m = 7'd30;   7'd11: m = 7'd33;
      7'd12: m = 7'd36;   7'd13: m = 7'd39;   7'd14: m = 7'd42;   7'd15: m = 7'd45;
      7'd16: m = 7'd48;   7'd17: m = 7'd51;   7'd18: m = 7'd54;   7'd19: m = 7'd57;
      7'd20: m = 7'd59;   7'd21: m = 7'd62;   7'd22: m = 7'd65;   7'd23: m = 7'd67;
      7'd24: m = 7'd70;   7'd25: m = 7'd73;   7'd26: m = 7'd75;   7'd27: m = 7'd78;
      7'd28: m = 7'd80;   7'd29: m = 7'd82;   7'd30: m = 7'd85;   7'd31: m = 7'd87;
      7'd32: m = 7'd89;   7'd33: m = 7'd91;   7'd34: m = 7'd94;   7'd35: m = 7'd96;
      7'd36: m = 7'd98;   7'd37: m = 7'd100;  7'd38: m = 7'd102;  7'd39: m = 7'd103;
      7'd40: m = 7'd105;  7'd41: m = 7'd107;  7'd42: m = 7'd108;  7'd43: m = 7'd110;
      7'd44: m = 7'd112;  7'd45: m = 7'd113;  7'd46: m = 7'd114;  7'd47: m = 7'd116;
      7'd48: m = 7'd117;  7'd49: m = 7'd118;  7'd50: m = 7'd119;  7'd51: m = 7'd120;
      7'd52: m = 7'd121;  7'd53: m = 7'd122;  7'd54: m = 7'd123;  7'd55: m = 7'd123;
      7'd56: m = 7'd124;  7'd57: m = 7'd125;  7'd58: m = 7'd125;  7'd59: m = 7'd126;
      7'd60: m = 7'd126;  7'd61: m = 7'd126;  7'd62: m = 7'd126;  7'd63: m = 7'd126;
      7'd64: m = 7'd127;
      default: m = 7'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### sv/eight_voice_wavetable_synth.sv
// ----------------------------------------------------------------------------
// eight_voice_wavetable_synth: eight-voice sound generator
// Register and PCM byte writes plus sample ticks in, one saturated stereo
// sample out per tick. The voice products share one registered multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall) carries operation, reg_addr, pcm_addr
//  and write_data. A transfer happens when in_valid is high and in_stall low.
//  Register and PCM writes give no result. A tick walks the voices 0..7
//  under a sequencer; each voice passes fetch, source, phase advance,
//  volume, DC blocker, pan and sweep checks, with ring modulation, the
//  filter, PCM steps, sync timer reloads and sweep steps where enabled.
//  The loop over voices and the single multiplier set the tick time.
//  in_stall is high while a tick is in progress.
//  The result sits in an output register (out_valid/out_stall); if the
//  receiver stalls, the finished tick waits there and the sequencer holds
//  before loading the next result. Register/PCM writes are still taken
//  while the sequencer is idle, but not while it holds in that wait.
//  After reset the PCM memory is cleared, one byte per cycle, with
//  in_stall high. mute_mask sits on an APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_voice_wavetable_synth #(
  parameter int PCM_RAM_BYTES = evws_pkg::PCM_RAM_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [7:0]         reg_addr,
  input  wire logic [12:0]        pcm_addr,
  input  wire logic [7:0]         write_data,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      left_sample,
  output logic signed [31:0]      right_sample,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int PCM_AW = $clog2(PCM_RAM_BYTES);
  localparam logic [15:0] PCM_MASK = 16'(PCM_RAM_BYTES - 1);
  localparam logic signed [17:0] PM18 = 18'(evws_pkg::PHASE_MULT);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLEAR = 5'd1;
  localparam logic [4:0] S_FETCH = 5'd2;
  localparam logic [4:0] S_SRC   = 5'd3;
  localparam logic [4:0] S_RING  = 5'd4;
  localparam logic [4:0] S_ADV   = 5'd5;
  localparam logic [4:0] S_SYNC  = 5'd6;
  localparam logic [4:0] S_PCM   = 5'd7;
  localparam logic [4:0] S_VOL   = 5'd8;
  localparam logic [4:0] S_VOLR  = 5'd9;
  localparam logic [4:0] S_F1    = 5'd10;
  localparam logic [4:0] S_F2    = 5'd11;
  localparam logic [4:0] S_F3    = 5'd12;
  localparam logic [4:0] S_F4    = 5'd13;
  localparam logic [4:0] S_F5    = 5'd14;
  localparam logic [4:0] S_DC    = 5'd15;
  localparam logic [4:0] S_DC2   = 5'd16;
  localparam logic [4:0] S_DC3   = 5'd17;
  localparam logic [4:0] S_PL    = 5'd18;
  localparam logic [4:0] S_PR    = 5'd19;
  localparam logic [4:0] S_PR2   = 5'd20;
  localparam logic [4:0] S_VCHK  = 5'd21;
  localparam logic [4:0] S_VT    = 5'd22;
  localparam logic [4:0] S_FCHK  = 5'd23;
  localparam logic [4:0] S_FT    = 5'd24;
  localparam logic [4:0] S_FS    = 5'd25;
  localparam logic [4:0] S_CCHK  = 5'd26;
  localparam logic [4:0] S_CT    = 5'd27;
  localparam logic [4:0] S_CS    = 5'd28;
  localparam logic [4:0] S_END   = 5'd29;
  localparam logic [4:0] S_OUT   = 5'd30;

  // ---------------------------------------------------------------- state
  logic [4:0]  state;
  logic [2:0]  vc;
  logic [PCM_AW-1:0] clr_cnt;
  logic [7:0]  mute_mask;

  logic [7:0]         vreg [8][32];
  logic [31:0]        osc_ph [8];
  logic [14:0]        pcm_frac [8];
  logic signed [17:0] sync_cnt [8];
  logic [7:0]         src_smp [8];
  logic [31:0]        flt_low [8];
  logic [31:0]        flt_band [8];
  logic [31:0]        dc_est [8];
  logic signed [17:0] tim_vol [8];
  logic signed [17:0] tim_frq [8];
  logic signed [17:0] tim_cut [8];
  logic [31:0]        noise [8];

  logic [7:0]         ring0;
  logic signed [17:0] tmr;
  logic               hit;
  logic [19:0]        facc;
  logic [31:0]        vs;
  logic [31:0]        hi_r;
  logic [31:0]        ereg;
  logic signed [35:0] lacc;
  logic signed [35:0] racc;
  logic signed [50:0] prod;

  logic [7:0] pcm_mem [PCM_RAM_BYTES];
  logic [7:0] pcm_q;

  // ---------------------------------------------------------------- fields
  logic [7:0]  rb [32];
  logic [15:0] freq16, cut16, pos16, bnd16, rst16, fspd, vspd, cspd, restim;
  logic [7:0]  vol8, pan8, f0, f1, duty, reson, famt, fbnd, vamt, vbnd, camt, cbnd;
  logic [2:0]  wave;
  logic        is_pcm;

  always_comb begin
    rb = vreg[vc];
  end

  assign freq16 = {rb[1], rb[0]};
  assign vol8   = rb[2];
  assign pan8   = rb[3];
  assign f0     = rb[4];
  assign f1     = rb[5];
  assign cut16  = {rb[7], rb[6]};
  assign duty   = rb[8];
  assign reson  = rb[9];
  assign pos16  = {rb[11], rb[10]};
  assign bnd16  = {rb[13], rb[12]};
  assign rst16  = {rb[15], rb[14]};
  assign fspd   = {rb[17], rb[16]};
  assign famt   = rb[18];
  assign fbnd   = rb[19];
  assign vspd   = {rb[21], rb[20]};
  assign vamt   = rb[22];
  assign vbnd   = rb[23];
  assign cspd   = {rb[25], rb[24]};
  assign camt   = rb[26];
  assign cbnd   = rb[27];
  assign restim = {rb[31], rb[30]};
  assign wave   = f0[2:0];
  assign is_pcm = f0[3];

  // ---------------------------------------------------------------- helpers
  function automatic logic [31:0] lfsr_next(input logic [31:0] l, input logic [2:0] wv,
                                            input logic [1:0] sel);
    logic fb;
    logic [31:0] t;
    if (wv == evws_pkg::WAVE_NOISE) begin
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      t = {fb, l[31:1]};
    end else begin
      case (sel)
        2'd0:    fb = l[3] ^ l[4];
        2'd1:    fb = l[2] ^ l[3];
        2'd2:    fb = l[0] ^ l[2] ^ l[3];
        default: fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      endcase
      t = {1'b0, l[31:1]};
      t[5] = t[5] | fb;
      if (t[5:0] == 6'd0) t = evws_pkg::NOISE_SEED;
    end
    return t;
  endfunction

  // one volume sweep step; returns {amt, vol}
  function automatic logic [15:0] vol_step(input logic [7:0] vol_i, input logic [7:0] amt_i,
                                           input logic [7:0] bnd_i);
    logic signed [9:0] v, m, b, bs, t;
    logic [7:0] a;
    v = {{2{vol_i[7]}}, vol_i};
    a = amt_i;
    m = {5'd0, amt_i[4:0]};
    b = {2'd0, bnd_i};
    bs = {{2{bnd_i[7]}}, bnd_i};
    if (a[5]) begin
      v = v + m;
      if (v > 10'sd127) v = 10'sd127;
      if (v > b && !a[6]) v = bs;
      if (v < 10'sd0) begin
        if (a[6]) begin
          if (a[7]) begin
            a[5] = ~a[5];
            t = 10'sd255 - v;
            v = {{2{t[7]}}, t[7:0]};
          end else begin
            v = v + 10'sd128;
          end
        end else begin
          v = 10'sd127;
        end
      end
    end else begin
      v = v - m;
      if (v < -10'sd128) v = -10'sd128;
      if (v < 10'sd0) begin
        if (a[6]) begin
          if (a[7]) begin
            a[5] = ~a[5];
            t = -v;
            v = {{2{t[7]}}, t[7:0]};
          end else begin
            v = v + 10'sd128;
          end
        end else begin
          v = 10'sd0;
        end
      end
      if (v < b && !a[6]) v = bs;
    end
    return {a, v[7:0]};
  endfunction

  // ---------------------------------------------------------------- source
  logic [31:0] ph_cur;
  logic [7:0]  idx, pulse8, tri8, sine8, noise8, src_comb, other;
  logic [6:0]  sq, sine_mag;

  assign ph_cur   = osc_ph[vc];
  assign idx      = ph_cur[21:14];
  assign pulse8   = ({1'b0, ph_cur[21:15]} > duty) ? 8'd127 : 8'd0;
  assign tri8     = idx[7] ? ~idx : idx;
  assign sq       = (idx[6:0] <= 7'd64) ? idx[6:0] : 7'(8'd128 - {1'b0, idx[6:0]});
  assign sine_mag = evws_pkg::sine_quarter(sq);
  assign sine8    = idx[7] ? 8'(-{1'b0, sine_mag}) : {1'b0, sine_mag};
  assign noise8   = noise[vc][0] ? 8'd127 : 8'd0;
  assign other    = (vc == 3'd7) ? ring0 : src_smp[3'(vc + 3'd1)];

  always_comb begin
    if (is_pcm) begin
      src_comb = pcm_q;
    end else begin
      case (wave)
        evws_pkg::WAVE_PULSE:     src_comb = pulse8;
        evws_pkg::WAVE_SAW:       src_comb = idx;
        evws_pkg::WAVE_SINE:      src_comb = sine8;
        evws_pkg::WAVE_TRIANGLE:  src_comb = tri8;
        evws_pkg::WAVE_NOISE:     src_comb = noise8;
        evws_pkg::WAVE_PNOISE:    src_comb = noise8;
        evws_pkg::WAVE_PULSE_SIN: src_comb = pulse8 ^ sine8;
        evws_pkg::WAVE_PULSE_TRI: src_comb = pulse8 ^ tri8;
        default:                  src_comb = pulse8;
      endcase
    end
  end

  // ---------------------------------------------------------------- advance
  logic [31:0] f32, step, step_pm, ph_adv, noise_adv;
  logic [18:0] fadd;
  logic [31:0] cut_pm;
  logic [16:0] ff;

  assign f32     = {16'd0, freq16};
  assign step    = (wave == evws_pkg::WAVE_PNOISE) ? ((f32 << duty[5:4]) - (f32 >> 3)) : f32;
  assign step_pm = 32'(step * evws_pkg::PHASE_MULT);
  assign ph_adv  = ph_cur + step_pm;
  assign noise_adv = ((ph_adv ^ ph_cur) & 32'h00F8_0000) != 32'd0
                   ? lfsr_next(noise[vc], wave, duty[5:4]) : noise[vc];
  assign fadd    = (freq16 > 16'h8000) ? 19'h08000 : 19'(f32 * evws_pkg::PHASE_MULT);
  assign cut_pm  = 32'({16'd0, cut16} * evws_pkg::PHASE_MULT);
  assign ff      = (cut_pm > 32'd32768) ? 17'h08000 : cut_pm[16:0];

  // PCM position step
  logic [15:0] pos_p1, pos_next;
  assign pos_p1 = pos16 + 16'd1;
  always_comb begin
    if (pos16 < bnd16) begin
      pos_next = ((pos_p1 == bnd16) && f1[2]) ? rst16 : pos_p1;
      pos_next = pos_next & PCM_MASK;
    end else if (f1[2]) begin
      pos_next = rst16;
    end else begin
      pos_next = pos16;
    end
  end

  // ---------------------------------------------------------------- sweeps
  logic [15:0] vstep;
  logic [6:0]  fm, cm;
  logic [15:0] f_next, c_next, c_add;
  assign vstep = vol_step(vol8, vamt, vbnd);
  assign fm    = famt[6:0];
  assign cm    = camt[6:0];
  assign c_add = cut16 + {9'd0, cm};

  always_comb begin
    if (famt[7]) begin
      if (freq16 > (16'hFFFF - {9'd0, fm})) begin
        f_next = 16'hFFFF;
      end else begin
        f_next = prod[22:7];
        if (f_next[15:8] > fbnd) f_next = {fbnd, 8'd0};
      end
    end else begin
      if (freq16 < {9'd0, fm}) begin
        f_next = 16'd0;
      end else begin
        f_next = prod[23:8];
        if (f_next[15:8] < fbnd) f_next = {fbnd, 8'd0};
      end
    end
  end

  always_comb begin
    if (camt[7]) begin
      if (cut16 > (16'hFFFF - {9'd0, cm})) begin
        c_next = 16'hFFFF;
      end else begin
        c_next = c_add;
        if (c_next[15:8] > cbnd) c_next = {cbnd, 8'd0};
      end
    end else begin
      if (cut16 < {9'd0, cm}) begin
        c_next = 16'd0;
      end else begin
        c_next = prod[26:11];
        if (c_next[15:8] < cbnd) c_next = {cbnd, 8'd0};
      end
    end
  end

  // ---------------------------------------------------------------- misc
  logic        tmr_le0;
  logic [31:0] ae;
  logic [31:0] e_sh, dc_new, band_new, flo_new, fsum;
  logic [7:0]  gl, gr;
  logic [35:0] pan_lo;

  assign tmr_le0  = tmr[17] || (tmr == 18'sd0);
  assign ae       = ereg[31] ? (32'd0 - ereg) : ereg;
  assign e_sh     = (ae > 32'd16384) ? 32'($signed(ereg) >>> 9) : 32'($signed(ereg) >>> 12);
  assign dc_new   = dc_est[vc] + e_sh;
  assign flo_new  = flt_low[vc] + prod[47:16];
  assign band_new = prod[47:16] + flt_band[vc];
  assign fsum     = (f0[5] ? flt_low[vc] : 32'd0) + (f0[6] ? hi_r : 32'd0)
                  + (f0[7] ? band_new : 32'd0);
  assign gl       = pan8[7] ? 8'd127 : (8'd127 - pan8);
  assign gr       = !pan8[7] ? 8'd127 : ((pan8 == 8'd128) ? 8'd0 : (pan8 - 8'd129));
  assign pan_lo   = prod[43:8];

  // ---------------------------------------------------------------- multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 18'sd0;
    case (state)
      S_SRC: begin
        mul_a = {{25{src_comb[7]}}, src_comb};
        mul_b = {{10{other[7]}}, other};
      end
      S_VOL: begin
        mul_a = {{25{src_smp[vc][7]}}, src_smp[vc]};
        mul_b = {{10{vol8[7]}}, vol8};
      end
      S_F1: begin
        mul_a = {flt_band[vc][31], flt_band[vc]};
        mul_b = {1'b0, ff};
      end
      S_F2: begin
        mul_a = {flt_band[vc][31], flt_band[vc]};
        mul_b = 18'(10'd256 - {2'd0, reson});
      end
      S_F4: begin
        mul_a = {hi_r[31], hi_r};
        mul_b = {1'b0, ff};
      end
      S_PL: begin
        mul_a = {vs[31], vs};
        mul_b = {10'd0, gl};
      end
      S_PR: begin
        mul_a = {vs[31], vs};
        mul_b = {10'd0, gr};
      end
      S_FT: begin
        mul_a = {17'd0, freq16};
        mul_b = famt[7] ? 18'(8'd128 + {1'b0, fm}) : 18'(8'd255 - {1'b0, fm});
      end
      S_CT: begin
        mul_a = {17'd0, cut16};
        mul_b = 18'(12'd2048 - {5'd0, cm});
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 18'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------- PCM memory
  logic              in_xfer;
  logic              pcm_we;
  logic [PCM_AW-1:0] pcm_wa, pcm_ra;
  logic [15:0]       pa16;

  assign in_xfer = in_valid && !in_stall;
  assign pa16    = {3'd0, pcm_addr};
  assign pcm_we  = (state == S_CLEAR) || (in_xfer && operation == evws_pkg::OP_PCM_WR);
  assign pcm_wa  = (state == S_CLEAR) ? clr_cnt : pa16[PCM_AW-1:0];
  assign pcm_ra  = pos16[PCM_AW-1:0];

  always_ff @(posedge clk) begin
    if (pcm_we) pcm_mem[pcm_wa] <= (state == S_CLEAR) ? 8'd0 : write_data;
    pcm_q <= pcm_mem[pcm_ra];
  end

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == evws_pkg::CFG_IDX_MUTE) ? {24'd0, mute_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_mask <= 8'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == evws_pkg::CFG_IDX_MUTE) begin
      mute_mask <= pwdata[7:0];
    end
  end

  assign in_stall = (state != S_IDLE);

  // saturation of the mix
  logic [31:0] lsat, rsat;
  assign lsat = (lacc > 36'sh07FFFFFFF) ? 32'h7FFF_FFFF :
                (lacc < -36'sh080000000) ? 32'h8000_0000 : lacc[31:0];
  assign rsat = (racc > 36'sh07FFFFFFF) ? 32'h7FFF_FFFF :
                (racc < -36'sh080000000) ? 32'h8000_0000 : racc[31:0];

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      vc        <= 3'd0;
      out_valid <= 1'b0;
      for (int v = 0; v < 8; v++) begin
        for (int k = 0; k < 32; k++) vreg[v][k] <= 8'd0;
        osc_ph[v]   <= 32'd0;
        pcm_frac[v] <= 15'd0;
        sync_cnt[v] <= 18'sd0;
        src_smp[v]  <= 8'd0;
        flt_low[v]  <= 32'd0;
        flt_band[v] <= 32'd0;
        dc_est[v]   <= 32'd0;
        tim_vol[v]  <= PM18;
        tim_frq[v]  <= PM18;
        tim_cut[v]  <= PM18;
        noise[v]    <= evws_pkg::NOISE_SEED;
      end
    end else begin
      // drop the result once taken
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_xfer) begin
            case (operation)
              evws_pkg::OP_REG_WR: vreg[reg_addr[7:5]][reg_addr[4:0]] <= write_data;
              evws_pkg::OP_TICK: begin
                ring0 <= src_smp[0];
                vc    <= 3'd0;
                lacc  <= 36'sd0;
                racc  <= 36'sd0;
                state <= S_FETCH;
              end
              default: ;
            endcase
          end
        end

        // PCM read is issued here, data lands in pcm_q
        S_FETCH: state <= S_SRC;

        S_SRC: begin
          if (f0[4]) begin
            state <= S_RING;
          end else begin
            src_smp[vc] <= src_comb;
            state <= S_ADV;
          end
        end

        S_RING: begin
          src_smp[vc] <= prod[14:7];
          state <= S_ADV;
        end

        S_ADV: begin
          if (is_pcm) begin
            facc  <= {5'd0, pcm_frac[vc]} + {1'b0, fadd};
            state <= S_PCM;
          end else begin
            osc_ph[vc] <= ph_adv;
            noise[vc]  <= noise_adv;
            if (f1[3] && restim != 16'd0) begin
              tmr   <= sync_cnt[vc] - PM18;
              hit   <= 1'b0;
              state <= S_SYNC;
            end else begin
              state <= S_VOL;
            end
          end
        end

        S_SYNC: begin
          if (tmr_le0) begin
            tmr <= tmr + $signed({2'd0, restim});
            hit <= 1'b1;
          end else begin
            sync_cnt[vc] <= tmr;
            if (hit) begin
              osc_ph[vc] <= 32'd0;
              noise[vc]  <= evws_pkg::NOISE_SEED;
            end
            state <= S_VOL;
          end
        end

        S_PCM: begin
          if (facc >= 20'd32768) begin
            facc <= facc - 20'd32768;
            vreg[vc][10] <= pos_next[7:0];
            vreg[vc][11] <= pos_next[15:8];
          end else begin
            pcm_frac[vc] <= facc[14:0];
            state <= S_VOL;
          end
        end

        S_VOL: state <= S_VOLR;

        S_VOLR: begin
          vs <= is_pcm ? prod[31:0] : prod[32:1];
          state <= (f0[7:5] != 3'd0) ? S_F1 : S_DC;
        end

        // state-variable filter
        S_F1: state <= S_F2;
        S_F2: begin
          flt_low[vc] <= flo_new;
          state <= S_F3;
        end
        S_F3: begin
          hi_r  <= vs - flt_low[vc] - prod[39:8];
          state <= S_F4;
        end
        S_F4: state <= S_F5;
        S_F5: begin
          flt_band[vc] <= band_new;
          vs    <= fsum;
          state <= S_DC;
        end

        // adaptive DC blocker
        S_DC: begin
          ereg  <= {vs[23:0], 8'd0} - dc_est[vc];
          state <= S_DC2;
        end
        S_DC2: begin
          dc_est[vc] <= dc_new;
          state <= S_DC3;
        end
        S_DC3: begin
          vs    <= vs - 32'($signed(dc_est[vc]) >>> 8);
          state <= S_PL;
        end

        // pan and accumulate
        S_PL: state <= S_PR;
        S_PR: begin
          if (!mute_mask[vc]) lacc <= lacc + $signed(pan_lo);
          state <= S_PR2;
        end
        S_PR2: begin
          if (!mute_mask[vc]) racc <= racc + $signed(pan_lo);
          state <= S_VCHK;
        end

        // volume sweep
        S_VCHK: begin
          if (f1[5] && vspd != 16'd0) begin
            tmr   <= tim_vol[vc] - PM18;
            state <= S_VT;
          end else begin
            state <= S_FCHK;
          end
        end
        S_VT: begin
          if (tmr_le0) begin
            tmr <= tmr + $signed({2'd0, vspd});
            vreg[vc][2]  <= vstep[7:0];
            vreg[vc][22] <= vstep[15:8];
          end else begin
            tim_vol[vc] <= tmr;
            state <= S_FCHK;
          end
        end

        // frequency sweep
        S_FCHK: begin
          if (f1[4] && fspd != 16'd0) begin
            tmr   <= tim_frq[vc] - PM18;
            state <= S_FT;
          end else begin
            state <= S_CCHK;
          end
        end
        S_FT: begin
          if (tmr_le0) begin
            tmr   <= tmr + $signed({2'd0, fspd});
            state <= S_FS;
          end else begin
            tim_frq[vc] <= tmr;
            state <= S_CCHK;
          end
        end
        S_FS: begin
          vreg[vc][0] <= f_next[7:0];
          vreg[vc][1] <= f_next[15:8];
          state <= S_FT;
        end

        // cutoff sweep
        S_CCHK: begin
          if (f1[6] && cspd != 16'd0) begin
            tmr   <= tim_cut[vc] - PM18;
            state <= S_CT;
          end else begin
            state <= S_END;
          end
        end
        S_CT: begin
          if (tmr_le0) begin
            tmr   <= tmr + $signed({2'd0, cspd});
            state <= S_CS;
          end else begin
            tim_cut[vc] <= tmr;
            state <= S_END;
          end
        end
        S_CS: begin
          vreg[vc][6] <= c_next[7:0];
          vreg[vc][7] <= c_next[15:8];
          state <= S_CT;
        end

        // one-shot phase reset, mute, next voice
        S_END: begin
          if (f1[0]) begin
            osc_ph[vc]   <= 32'd0;
            sync_cnt[vc] <= $signed({2'd0, restim});
            vreg[vc][5]  <= f1 & 8'hFE;
          end
          if (mute_mask[vc]) begin
            flt_low[vc]  <= 32'd0;
            flt_band[vc] <= 32'd0;
          end
          vc <= vc + 3'd1;
          state <= (vc == 3'd7) ? S_OUT : S_FETCH;
        end

        // hold until the output register is free
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            left_sample  <= lsat;
            right_sample <= rsat;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
